// ===== rtl/core/plht_pkg.sv =====
// ----------------------------------------------------------------------------
// plht_pkg
// Shared constants and types for the polyline hit test: slop, default
// coordinate width, queue flags and the segment engine state encoding.
// ----------------------------------------------------------------------------
package plht_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int WIDTH_BITS     = 10;
  localparam int LIMIT_W        = 11;
  localparam int SLOP           = 2;

  // Flags that travel with every queued word
  typedef struct packed {
    logic seg;       // word carries a segment
    logic nrm_zero;  // degenerate segment, no division
    logic last;      // final vertex of the polyline
  } seg_flags_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DINIT,
    BK_DIV,
    BK_ACC,
    BK_CHK
  } bk_state_t;

endpackage

// ===== rtl/core/polyline_hit_test.sv =====
// ----------------------------------------------------------------------------
// polyline_hit_test
// Tests whether a query point lies on a polyline of a given line width.
// ----------------------------------------------------------------------------
// Vertices are pushed one at a time with the query point and width; a single
// word on the result side (hit) follows each vertex marked last. The intake
// accepts a vertex whenever the queue is not full and forwards segments
// through a two-word queue to the segment engine. The engine finishes one
// queued word before it pops the next; a segment passes through its shared
// multiplier and a divider that retires two quotient bits a cycle, while a
// degenerate segment or a lone final vertex skips both. The queue holds up
// to two further segment or final-vertex words while a segment is under way,
// and one result waiting in the output register does not block new input.
module polyline_hit_test #(
  parameter int COORD_BITS = plht_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic signed [COORD_BITS-1:0]    in_vertex_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex_y,
  input  logic signed [COORD_BITS-1:0]    in_query_x,
  input  logic signed [COORD_BITS-1:0]    in_query_y,
  input  logic [plht_pkg::WIDTH_BITS-1:0] in_line_width,
  input  logic                            in_last_vertex,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_hit
);
  import plht_pkg::*;

  localparam int DATA_W = 4 * (COORD_BITS + 1) + (COORD_BITS + 2) + LIMIT_W;
  localparam int FLAG_W = $bits(seg_flags_t);

  logic                     q_push, q_full, q_pop, q_empty;
  seg_flags_t               f_flags, b_flags;
  logic [DATA_W-1:0]        f_data, b_data;
  logic [FLAG_W+DATA_W-1:0] q_rd;

  plht_front #(
    .COORD_BITS (COORD_BITS),
    .DATA_W     (DATA_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .in_line_width  (in_line_width),
    .in_last_vertex (in_last_vertex),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_flags        (f_flags),
    .q_data         (f_data)
  );

  plht_fifo #(
    .WIDTH (FLAG_W + DATA_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_flags, f_data}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  assign b_flags = q_rd[FLAG_W+DATA_W-1:DATA_W];
  assign b_data  = q_rd[DATA_W-1:0];

  plht_back #(
    .COORD_BITS (COORD_BITS),
    .DATA_W     (DATA_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_flags   (b_flags),
    .q_data    (b_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_hit   (out_hit)
  );

endmodule

// ===== rtl/core/plht_front.sv =====
// ----------------------------------------------------------------------------
// plht_front
// Vertex intake: holds the previous vertex, forms the segment normal, its L1
// norm, the offsets of the query point and the hit limit, and queues a word
// for every segment and for the final vertex.
// ----------------------------------------------------------------------------
module plht_front #(
  parameter int COORD_BITS = 16,
  parameter int DATA_W     = 4 * (COORD_BITS + 1) + (COORD_BITS + 2) + 11
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [COORD_BITS-1:0]           in_vertex_x,
  input  logic signed [COORD_BITS-1:0]           in_vertex_y,
  input  logic signed [COORD_BITS-1:0]           in_query_x,
  input  logic signed [COORD_BITS-1:0]           in_query_y,
  input  logic [plht_pkg::WIDTH_BITS-1:0]        in_line_width,
  input  logic                                   in_last_vertex,
  input  logic                                   q_full,
  output logic                                   q_push,
  output plht_pkg::seg_flags_t                   q_flags,
  output logic [DATA_W-1:0]                      q_data
);
  import plht_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int NW = COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] prev_x_r, prev_x_nxt;
  logic signed [COORD_BITS-1:0] prev_y_r, prev_y_nxt;
  logic                         have_prev_r, have_prev_nxt;

  logic                 accept;
  logic signed [DW-1:0] dx, dy, nx, ny;
  logic [DW-1:0]        nx_abs, ny_abs;
  logic [NW-1:0]        nrm;
  logic [LIMIT_W-1:0]   limit;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  assign dx = DW'(in_query_x) - DW'(in_vertex_x);
  assign dy = DW'(in_query_y) - DW'(in_vertex_y);
  assign nx = DW'(prev_y_r) - DW'(in_vertex_y);
  assign ny = DW'(in_vertex_x) - DW'(prev_x_r);

  assign nx_abs = nx[DW-1] ? DW'(-nx) : DW'(nx);
  assign ny_abs = ny[DW-1] ? DW'(-ny) : DW'(ny);
  assign nrm    = NW'(nx_abs) + NW'(ny_abs);
  assign limit  = LIMIT_W'(in_line_width) + LIMIT_W'(SLOP);

  assign q_push           = accept && (have_prev_r || in_last_vertex);
  assign q_flags.seg      = have_prev_r;
  assign q_flags.nrm_zero = (nrm == '0);
  assign q_flags.last     = in_last_vertex;
  assign q_data           = {dx, dy, nx, ny, nrm, limit};

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (in_last_vertex) begin
        // start afresh with the next polyline
        prev_x_nxt    = '0;
        prev_y_nxt    = '0;
        have_prev_nxt = 1'b0;
      end else begin
        prev_x_nxt    = in_vertex_x;
        prev_y_nxt    = in_vertex_y;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
  end

endmodule

// ===== rtl/core/plht_fifo.sv =====
// ----------------------------------------------------------------------------
// plht_fifo
// Two-word queue between the vertex intake and the segment engine.
// ----------------------------------------------------------------------------
module plht_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/plht_back.sv =====
// ----------------------------------------------------------------------------
// plht_back
// Segment engine: one shared multiplier and a two-bit-per-cycle restoring
// divider form z from the queued segment, test it against the limit, collect
// the hit flag and hand the result to a one-word output register.
// ----------------------------------------------------------------------------
module plht_back #(
  parameter int COORD_BITS = 16,
  parameter int DATA_W     = 4 * (COORD_BITS + 1) + (COORD_BITS + 2) + 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  plht_pkg::seg_flags_t q_flags,
  input  logic [DATA_W-1:0]    q_data,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_hit
);
  import plht_pkg::*;

  localparam int DW    = COORD_BITS + 1;
  localparam int NW    = COORD_BITS + 2;
  localparam int PW    = 2 * COORD_BITS + 2;
  localparam int ZW    = COORD_BITS + 3;
  localparam int QB    = ((COORD_BITS + 2) / 2) * 2;  // quotient bits, even
  localparam int STEPS = QB / 2;
  localparam int CNTW  = $clog2(STEPS);

  bk_state_t state_r, state_nxt;

  logic signed [DW-1:0] dx_in, dy_in, nx_in, ny_in;
  logic [NW-1:0]        nrm_in;
  logic [LIMIT_W-1:0]   limit_in;

  logic signed [DW-1:0] dx_r, dx_nxt, dy_r, dy_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  logic [NW-1:0]        nrm_r, nrm_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic                 seg_r, seg_nxt;
  logic                 last_r, last_nxt;
  logic                 sel_r, sel_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic                 neg_r, neg_nxt;
  logic [NW-1:0]        rem_r, rem_nxt;
  logic [QB-1:0]        quo_r, quo_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 hit_r, hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;

  logic [PW-1:0]        mag;
  logic [NW:0]          t1, t2;
  logic [NW-1:0]        r1, r2;
  logic                 b1, b2;
  logic signed [ZW-1:0] qs;
  logic [ZW-1:0]        z_abs;
  logic                 seg_hit;

  assign {dx_in, dy_in, nx_in, ny_in, nrm_in, limit_in} = q_data;

  assign out_empty = !out_valid_r;
  assign out_hit   = out_hit_r;

  // two restoring steps a cycle
  always_comb begin
    t1 = {rem_r, quo_r[QB-1]};
    b1 = (t1 >= {1'b0, nrm_r});
    r1 = b1 ? NW'(t1 - {1'b0, nrm_r}) : t1[NW-1:0];
    t2 = {r1, quo_r[QB-2]};
    b2 = (t2 >= {1'b0, nrm_r});
    r2 = b2 ? NW'(t2 - {1'b0, nrm_r}) : t2[NW-1:0];
  end

  assign mag     = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  assign qs      = neg_r ? -$signed(ZW'(quo_r)) : $signed(ZW'(quo_r));
  assign z_abs   = z_r[ZW-1] ? ZW'(-z_r) : ZW'(z_r);
  assign seg_hit = seg_r && (z_abs < ZW'(limit_r));

  always_comb begin
    state_nxt     = state_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    nrm_nxt       = nrm_r;
    limit_nxt     = limit_r;
    seg_nxt       = seg_r;
    last_nxt      = last_r;
    sel_nxt       = sel_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    z_nxt         = z_r;
    hit_nxt       = hit_r;
    out_hit_nxt   = out_hit_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          dx_nxt    = dx_in;
          dy_nxt    = dy_in;
          nx_nxt    = nx_in;
          ny_nxt    = ny_in;
          nrm_nxt   = nrm_in;
          limit_nxt = limit_in;
          seg_nxt   = q_flags.seg;
          last_nxt  = q_flags.last;
          sel_nxt   = 1'b0;
          z_nxt     = '0;
          if (!q_flags.seg) begin
            state_nxt = BK_CHK;
          end else if (q_flags.nrm_zero) begin
            z_nxt     = ZW'(dx_in) + ZW'(dy_in);
            state_nxt = BK_CHK;
          end else begin
            state_nxt = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        prod_nxt  = sel_r ? PW'(dy_r) * PW'(ny_r) : PW'(dx_r) * PW'(nx_r);
        state_nxt = BK_DINIT;
      end
      BK_DINIT: begin
        // quotient fits in QB bits, so the top part is already below nrm
        neg_nxt   = prod_r[PW-1];
        rem_nxt   = NW'(mag >> QB);
        quo_nxt   = mag[QB-1:0];
        cnt_nxt   = CNTW'(STEPS - 1);
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        rem_nxt = r2;
        quo_nxt = {quo_r[QB-3:0], b1, b2};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          state_nxt = BK_ACC;
        end
      end
      BK_ACC: begin
        z_nxt = z_r + qs;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = BK_MUL;
        end else begin
          state_nxt = BK_CHK;
        end
      end
      BK_CHK: begin
        if (!last_r) begin
          hit_nxt   = hit_r || seg_hit;
          state_nxt = BK_IDLE;
        end else if (!out_valid_r || out_pop) begin
          out_hit_nxt   = hit_r || seg_hit;
          out_valid_nxt = 1'b1;
          hit_nxt       = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    nrm_r     <= nrm_nxt;
    limit_r   <= limit_nxt;
    seg_r     <= seg_nxt;
    last_r    <= last_nxt;
    sel_r     <= sel_nxt;
    prod_r    <= prod_nxt;
    neg_r     <= neg_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    z_r       <= z_nxt;
    out_hit_r <= out_hit_nxt;
  end

endmodule
